// ----- rtl/core/slip_pkg.sv -----
// Shared types, status codes and constants for the sorted table interpolator.
package slip_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DVD_W = 32;
    localparam int DVS_W = 16;

    typedef enum logic [2:0] {
        ST_EXACT  = 3'd0,
        ST_INTERP = 3'd1,
        ST_RANGE  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_LOADED = 3'd4,
        ST_FULL   = 3'd5
    } status_t;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] lift;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/slip_ifs.sv -----
// Request and response channel interfaces of the interpolator.
interface slip_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] angle_in;
    logic signed [15:0] lift_in;

    modport source (output valid, output req_type, output angle_in, output lift_in,
                    input ready);
    modport sink (input valid, input req_type, input angle_in, input lift_in,
                  output ready);
endinterface

interface slip_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] lift_out;
    logic [2:0]         status;

    modport source (output valid, output lift_out, output status, input ready);
    modport sink (input valid, input lift_out, input status, output ready);
endinterface

// ----- rtl/core/sorted_table_linear_interpolator.sv -----
// A load stores its pair unless the table is full; a query reads and compares the entries in order
// and, when it interpolates, then multiplies and runs the 32-step divider.
// A query after an out of order load first sorts the table in place.
// Requests are taken one at a time: the block is ready only while idle.
// Reset clears the pair count and marks the table as sorted; the table memory is not cleared.
module sorted_table_linear_interpolator #(
    parameter int TABLE_DEPTH = slip_pkg::TABLE_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    slip_req_if.sink  req,
    slip_rsp_if.source rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SORT_START, S_SORT_FIRST, S_SORT_RD, S_SORT_CMP, S_SORT_W1, S_SORT_W2,
        S_Q_RD, S_Q_CMP, S_MUL, S_DIV_START, S_DIV_WAIT, S_RESP
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic               sorted_reg;
    logic signed [15:0] last_reg;
    logic signed [15:0] max_reg;
    logic signed [15:0] b_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      best_reg;
    slip_pkg::entry_t   best_val_reg;
    slip_pkg::entry_t   cur_val_reg;
    slip_pkg::entry_t   prev_reg;
    logic signed [16:0] da_reg;
    logic signed [16:0] dl_reg;
    logic [15:0]        dc_reg;
    logic signed [33:0] prod_reg;
    logic               neg_reg;
    logic signed [15:0] res_lift_reg;
    slip_pkg::status_t  res_status_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_lift_reg;
    slip_pkg::status_t  out_status_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    slip_pkg::entry_t   mem_wdata;
    slip_pkg::entry_t   mem_rdata;
    slip_pkg::div_req_t div_req;
    slip_pkg::div_rsp_t div_rsp;
    logic               accept;
    logic [33:0]        mag;
    logic signed [17:0] qs;
    logic signed [17:0] sum;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !req.req_type && count_reg != CW'(TABLE_DEPTH))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = count_reg[AW-1:0];
                    mem_wdata = '{angle: req.angle_in, lift: req.lift_in};
                end
            end
            S_SORT_START: mem_raddr = i_reg[AW-1:0];
            S_SORT_RD:    mem_raddr = j_reg[AW-1:0];
            S_Q_RD:       mem_raddr = j_reg[AW-1:0];
            S_SORT_W1:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[AW-1:0];
                mem_wdata = best_val_reg;
            end
            S_SORT_W2:
            begin
                mem_we    = 1'b1;
                mem_waddr = best_reg[AW-1:0];
                mem_wdata = cur_val_reg;
            end
            default:
            begin
            end
        endcase
    end

    slip_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mag              = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);
    assign div_req.start    = (state_reg == S_DIV_START);
    assign div_req.dividend = mag[slip_pkg::DVD_W-1:0];
    assign div_req.divisor  = dc_reg;

    slip_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign qs  = neg_reg ? -$signed({1'b0, div_rsp.quotient[16:0]})
                         : $signed({1'b0, div_rsp.quotient[16:0]});
    assign sum = 18'(prev_reg.lift) + qs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sorted_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != S_RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_lift_reg <= '0;
                        b_reg        <= req.angle_in;
                        if (!req.req_type)
                        begin
                            state_reg <= S_RESP;
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                res_status_reg <= slip_pkg::ST_FULL;
                            end
                            else
                            begin
                                res_status_reg <= slip_pkg::ST_LOADED;
                                count_reg      <= count_reg + 1'b1;
                                last_reg       <= req.angle_in;
                                if (count_reg != '0 && req.angle_in < last_reg)
                                begin
                                    sorted_reg <= 1'b0;
                                end
                                if (count_reg == '0 || req.angle_in > max_reg)
                                begin
                                    max_reg <= req.angle_in;
                                end
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_reg <= slip_pkg::ST_EMPTY;
                            state_reg      <= S_RESP;
                        end
                        else if (!sorted_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_SORT_START;
                        end
                        else
                        begin
                            j_reg     <= '0;
                            state_reg <= S_Q_RD;
                        end
                    end
                end
                S_SORT_START: state_reg <= S_SORT_FIRST;
                S_SORT_FIRST:
                begin
                    best_reg     <= i_reg;
                    best_val_reg <= mem_rdata;
                    cur_val_reg  <= mem_rdata;
                    j_reg        <= i_reg + 1'b1;
                    state_reg    <= S_SORT_RD;
                end
                S_SORT_RD: state_reg <= S_SORT_CMP;
                S_SORT_CMP:
                begin
                    if (best_val_reg.angle > mem_rdata.angle)
                    begin
                        best_reg     <= j_reg;
                        best_val_reg <= mem_rdata;
                    end
                    if (j_reg + 1'b1 == count_reg)
                    begin
                        state_reg <= S_SORT_W1;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SORT_RD;
                    end
                end
                S_SORT_W1: state_reg <= S_SORT_W2;
                S_SORT_W2:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (i_reg + CW'(2) == count_reg)
                    begin
                        sorted_reg <= 1'b1;
                        last_reg   <= max_reg;
                        j_reg      <= '0;
                        state_reg  <= S_Q_RD;
                    end
                    else
                    begin
                        state_reg <= S_SORT_START;
                    end
                end
                S_Q_RD: state_reg <= S_Q_CMP;
                S_Q_CMP:
                begin
                    if (mem_rdata.angle == b_reg)
                    begin
                        res_lift_reg   <= mem_rdata.lift;
                        res_status_reg <= slip_pkg::ST_EXACT;
                        state_reg      <= S_RESP;
                    end
                    else if (mem_rdata.angle > b_reg)
                    begin
                        if (j_reg == '0)
                        begin
                            res_status_reg <= slip_pkg::ST_RANGE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            da_reg    <= 17'(b_reg) - 17'(prev_reg.angle);
                            dc_reg    <= 16'(17'(mem_rdata.angle) - 17'(prev_reg.angle));
                            dl_reg    <= 17'(mem_rdata.lift) - 17'(prev_reg.lift);
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        prev_reg <= mem_rdata;
                        if (j_reg + 1'b1 == count_reg)
                        begin
                            res_status_reg <= slip_pkg::ST_RANGE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_Q_RD;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= da_reg * dl_reg;
                    state_reg <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    neg_reg   <= prod_reg[33];
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        res_lift_reg   <= sum[15:0];
                        res_status_reg <= slip_pkg::ST_INTERP;
                        state_reg      <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_lift_reg   <= res_lift_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.lift_out = out_lift_reg;
    assign rsp.status   = out_status_reg;

endmodule

// ----- rtl/core/slip_table.sv -----
// Synchronous single-port-write, one-read table memory of angle and lift pairs.
module slip_table #(
    parameter int TABLE_DEPTH = slip_pkg::TABLE_DEPTH_DEF,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  slip_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output slip_pkg::entry_t rdata
);

    slip_pkg::entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/slip_div.sv -----
// Restoring unsigned divider that produces one quotient bit per cycle.
module slip_div (
    input  logic               clk,
    input  logic               rst_n,
    input  slip_pkg::div_req_t req,
    output slip_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(slip_pkg::DVD_W + 1);

    logic [slip_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [slip_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [slip_pkg::DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [slip_pkg::DVS_W:0]   trial;
    logic [slip_pkg::DVS_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[slip_pkg::DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[slip_pkg::DVS_W-1:0];
            quo_next = {quo_reg[slip_pkg::DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[slip_pkg::DVS_W-1:0];
            quo_next = {quo_reg[slip_pkg::DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(slip_pkg::DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/slip_chk.sv -----
// Port-level checker for the interpolator, bound to the top level.
module slip_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] lift_out,
    input logic [2:0]  status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lift_out) && $stable(status))
        else $error("Response changed while stalled.");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != slip_pkg::ST_EXACT && status != slip_pkg::ST_INTERP
        |-> lift_out == 16'd0)
        else $error("Nonzero lift with a non-lookup status.");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second request was taken while one is in flight.");

endmodule

bind sorted_table_linear_interpolator slip_chk u_slip_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .lift_out  (rsp.lift_out),
    .status    (rsp.status)
);
